[sv/euler_rotation_matrix_macros.svh]
// Assertion macros for the Euler rotation matrix generator.
// Used by the checker module; has no other dependencies.
`ifndef EULER_ROTATION_MATRIX_MACROS_SVH
`define EULER_ROTATION_MATRIX_MACROS_SVH
`define ERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ERM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[sv/erm_pkg.sv]
// Shared constants and types for the Euler rotation matrix generator.
// No dependencies.
`default_nettype none
package erm_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_BITS = FRAC_BITS + 2;
  localparam int ITERS = 30;
  localparam int WF = 30;
  localparam int TW = 34;
  localparam int PW = 66;
  localparam logic signed [TW-1:0] GAIN = 34'sd652032874;
  localparam logic signed [TW-1:0] ONE = 34'sd1073741824;
  localparam logic signed [31:0] ATAN [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
  localparam int LAT = ITERS + 6;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  function automatic logic signed [OUT_BITS-1:0] finish(input prod_t v, input int sh);
    prod_t r;
    prod_t lim;
    r = (v + (prod_t'(1) <<< (sh - 1))) >>> sh;
    lim = prod_t'(1) <<< FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[OUT_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

[sv/erm_cordic.sv]
// Pipelined CORDIC lane: sine and cosine in Q30 of one binary angle.
// Depends on erm_pkg.
`default_nettype none
module erm_cordic import erm_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output sc_t sc
);
  trig_t x [ITERS+1];
  trig_t y [ITERS+1];
  logic signed [32:0] z [ITERS+1];
  logic flip [ITERS+1];
  logic [31:0] a;
  logic [31:0] a2;
  logic q;

  always_comb begin
    a = {angle, {(32-ANGLE_BITS){1'b0}}};
    q = a[31] ^ a[30];
    a2 = q ? a + 32'h80000000 : a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GAIN;
      y[0] <= '0;
      z[0] <= {a2[31], a2};
      flip[0] <= q;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][32]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - {ATAN[i][31], ATAN[i]};
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + {ATAN[i][31], ATAN[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    trig_t xc;
    trig_t yc;
    xc = x[ITERS] > ONE ? ONE : (x[ITERS] < -ONE ? -ONE : x[ITERS]);
    yc = y[ITERS] > ONE ? ONE : (y[ITERS] < -ONE ? -ONE : y[ITERS]);
    if (en) begin
      sc.c <= flip[ITERS] ? -xc : xc;
      sc.s <= flip[ITERS] ? -yc : yc;
    end
  end
endmodule
`default_nettype wire

[sv/erm_merge.sv]
// Merging stage: combines the three lanes' sines and cosines into the matrix.
// Depends on erm_pkg.
`default_nettype none
module erm_merge import erm_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire sc_t sx,
  input  wire sc_t sy,
  input  wire sc_t sz,
  output logic [9*OUT_BITS-1:0] m
);
  prod_t sysx;
  prod_t sycx;
  trig_t cz1, sz1, sy1;
  prod_t p00, p10, p21, p22, pczcx, pczsx, pszcx, pszsx;
  trig_t sysx_r, sycx_r, cz2, sz2, sy2, sy3;
  prod_t p00b, p10b, p21b, p22b, pczcxb, pczsxb, pszcxb, pszsxb;
  prod_t p00c, p10c, p21c, p22c;
  prod_t a1, a2, a4, a5;

  always_ff @(posedge clk) begin
    if (en) begin
      sysx <= prod_t'(sy.s) * prod_t'(sx.s);
      sycx <= prod_t'(sy.s) * prod_t'(sx.c);
      p00 <= prod_t'(sz.c) * prod_t'(sy.c);
      p10 <= prod_t'(sz.s) * prod_t'(sy.c);
      p21 <= prod_t'(sy.c) * prod_t'(sx.s);
      p22 <= prod_t'(sy.c) * prod_t'(sx.c);
      pczcx <= prod_t'(sz.c) * prod_t'(sx.c);
      pczsx <= prod_t'(sz.c) * prod_t'(sx.s);
      pszcx <= prod_t'(sz.s) * prod_t'(sx.c);
      pszsx <= prod_t'(sz.s) * prod_t'(sx.s);
      cz1 <= sz.c; sz1 <= sz.s; sy1 <= sy.s;
      sysx_r <= trig_t'((sysx + (prod_t'(1) <<< (WF - 1))) >>> WF);
      sycx_r <= trig_t'((sycx + (prod_t'(1) <<< (WF - 1))) >>> WF);
      cz2 <= cz1; sz2 <= sz1; sy2 <= sy1;
      p00b <= p00; p10b <= p10; p21b <= p21; p22b <= p22;
      pczcxb <= pczcx; pczsxb <= pczsx; pszcxb <= pszcx; pszsxb <= pszsx;
      a1 <= prod_t'(cz2) * prod_t'(sysx_r) - pszcxb;
      a2 <= prod_t'(cz2) * prod_t'(sycx_r) + pszsxb;
      a4 <= prod_t'(sz2) * prod_t'(sysx_r) + pczcxb;
      a5 <= prod_t'(sz2) * prod_t'(sycx_r) - pczsxb;
      p00c <= p00b; p10c <= p10b; p21c <= p21b; p22c <= p22b;
      sy3 <= sy2;
      m <= {finish(p22c, 2*WF-FRAC_BITS), finish(p21c, 2*WF-FRAC_BITS),
            finish(-prod_t'(sy3), WF-FRAC_BITS), finish(a5, 2*WF-FRAC_BITS),
            finish(a4, 2*WF-FRAC_BITS), finish(p10c, 2*WF-FRAC_BITS),
            finish(a2, 2*WF-FRAC_BITS), finish(a1, 2*WF-FRAC_BITS),
            finish(p00c, 2*WF-FRAC_BITS)};
    end
  end
endmodule
`default_nettype wire

[sv/euler_rotation_matrix.sv]
// Euler rotation matrix (Rz*Ry*Rx) generator, top level.
// Throughput: one request per cycle while the output is not stalled, as every lane and the merge are fully pipelined.
// The whole pipeline advances together and halts while a result waits.
// Synchronous active-high reset clears the valid flags only.
`default_nettype none
module euler_rotation_matrix import erm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // angle_x, angle_y, angle_z
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [143:0] m_axis_tdata        // m00, m01, m02, m10 .. m22
);
  logic en;
  logic [LAT-1:0] vld;
  sc_t scx, scy, scz;

  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  erm_cordic u_x (.clk, .en, .angle(s_axis_tdata[15:0]), .sc(scx));
  erm_cordic u_y (.clk, .en, .angle(s_axis_tdata[31:16]), .sc(scy));
  erm_cordic u_z (.clk, .en, .angle(s_axis_tdata[47:32]), .sc(scz));
  erm_merge u_m (.clk, .en, .sx(scx), .sy(scy), .sz(scz), .m(m_axis_tdata));
endmodule
`default_nettype wire

[sv/erm_checker.sv]
// Port-level checker for the Euler rotation matrix generator, with its bind.
// Depends on euler_rotation_matrix_macros.svh.
`default_nettype none
`include "euler_rotation_matrix_macros.svh"
module erm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [143:0] m_axis_tdata
);
  `ERM_ASSERT_RST(a_rst, rst |=> !m_axis_tvalid, "valid after reset")
  `ERM_ASSERT(a_ready, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "ready while stalled")
  `ERM_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result moved")
endmodule
bind euler_rotation_matrix erm_checker u_chk (.*);
`default_nettype wire
